// ===== src/luts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the LU triangular solve and inverse block.
// Depends on nothing; the divider, datapath, controller and top files import it.
package luts_pkg;

  localparam int DEF_MAX_ORDER = 8;
  localparam int DEF_FRAC_BITS = 16;
  localparam int IDXW = 3;
  localparam int DATAW = 32;
  localparam int SIZEW = 4;
  localparam int CFG_ADDRW = 3;

  localparam logic [1:0] TGT_LOWER = 2'd0;
  localparam logic [1:0] TGT_UPPER = 2'd1;
  localparam logic [1:0] TGT_RHS = 2'd2;

  localparam logic REG_SIZE = 1'b0;
  localparam logic REG_MODE = 1'b1;
  localparam logic [SIZEW-1:0] SIZE_RST = 4'd8;
  localparam logic MODE_SOLVE = 1'b0;
  localparam logic MODE_INVERT = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_INIT = 10'b00_0000_0010,
    S_RD   = 10'b00_0000_0100,
    S_MUL  = 10'b00_0000_1000,
    S_ACC  = 10'b00_0001_0000,
    S_FST  = 10'b00_0010_0000,
    S_RDD  = 10'b00_0100_0000,
    S_DIV  = 10'b00_1000_0000,
    S_DIVW = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic            load;
    logic            acc_init;
    logic            mem_rd;
    logic            mul;
    logic            acc_upd;
    logic            fwd_wr;
    logic            div_start;
    logic            sol_wr;
    logic            out_ld;
    logic            out_last;
    logic            back;
    logic            unit;
    logic [IDXW-1:0] ri;
    logic [IDXW-1:0] rj;
    logic [IDXW-1:0] oc;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== src/luts_if.sv =====
`timescale 1ns / 1ps
// Request channel interfaces for the load side and the result side.
// Depends on nothing.
interface luts_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         target;
  logic [2:0]         row;
  logic [2:0]         col;
  logic signed [31:0] value;
  logic               start_req;
  modport source(output valid, target, row, col, value, start_req, input ready);
  modport sink(input valid, target, row, col, value, start_req, output ready);
endinterface

interface luts_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_row;
  logic [2:0]         out_col;
  logic signed [31:0] out_value;
  logic               error;
  logic               last;
  modport source(output valid, out_row, out_col, out_value, error, last, input ready);
  modport sink(input valid, out_row, out_col, out_value, error, last, output ready);
endinterface

// ===== src/luts_div.sv =====
`timescale 1ns / 1ps
// Restoring Q-format divider, one quotient bit per cycle, with saturation.
// Depends on luts_pkg.
module luts_div import luts_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [31:0] quot,
  output logic               err
);

  localparam int NUMW = 32 + FRAC_BITS;
  localparam int CNTW = $clog2(NUMW + 1);
  localparam logic [NUMW-1:0] LIM = {{(NUMW-32){1'b0}}, 32'h8000_0000};

  logic            busy_r, done_r, zero_r, neg_r, eneg_r;
  logic [CNTW-1:0] cnt_r;
  logic [NUMW-1:0] num_r, q_r;
  logic [32:0]     rem_r, trial;
  logic [31:0]     den_r, emag, dmag;

  assign emag = dividend[31] ? (~dividend + 32'd1) : dividend;
  assign dmag = divisor[31] ? (~divisor + 32'd1) : divisor;
  assign trial = {rem_r[31:0], num_r[NUMW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NUMW);
        zero_r <= (divisor == 32'sd0);
        eneg_r <= dividend[31];
        neg_r  <= dividend[31] ^ divisor[31];
        num_r  <= {emag, {FRAC_BITS{1'b0}}};
        den_r  <= dmag;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        if (zero_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          num_r <= {num_r[NUMW-2:0], 1'b0};
          if (trial >= {1'b0, den_r}) begin
            rem_r <= trial - {1'b0, den_r};
            q_r   <= {q_r[NUMW-2:0], 1'b1};
          end else begin
            rem_r <= trial;
            q_r   <= {q_r[NUMW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - CNTW'(1);
          if (cnt_r == CNTW'(1)) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign done = done_r;

  always_comb begin
    if (zero_r) begin
      err  = 1'b1;
      quot = eneg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (neg_r) begin
      err  = (q_r > LIM);
      quot = err ? 32'sh8000_0000 : signed'(~q_r[31:0] + 32'd1);
    end else begin
      err  = (q_r >= LIM);
      quot = err ? 32'sh7fff_ffff : signed'(q_r[31:0]);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without work");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
`endif

endmodule

// ===== src/luts_dp.sv =====
`timescale 1ns / 1ps
// Datapath: factor memories, vectors, multiply-accumulate, divider, result register.
// Depends on luts_pkg and luts_div.
module luts_dp import luts_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         in_target,
  input  logic [2:0]         in_row,
  input  logic [2:0]         in_col,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [31:0] out_value,
  output logic               out_error,
  output logic               out_last
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int AW = 2 * IW;
  localparam int DEPTH = 2 ** AW;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [64:0] SMAX = 65'sh0_7fff_ffff;
  localparam logic signed [64:0] SMIN = -65'sh0_8000_0000;

  logic signed [31:0] low_mem [DEPTH];
  logic signed [31:0] up_mem [DEPTH];
  logic signed [31:0] low_rd_r, up_rd_r;
  logic signed [31:0] rhs_r [MAX_ORDER];
  logic signed [31:0] fwd_r [MAX_ORDER];
  logic signed [31:0] sol_r [MAX_ORDER];
  logic [MAX_ORDER-1:0] fwd_err_r, sol_err_r;

  logic signed [31:0] acc_r, op_rd, vec, div_q;
  logic               err_r, verr_r, div_err, div_done;
  logic signed [63:0] prod_r, rnd;
  logic signed [64:0] diff;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [IW-1:0]      ri, rj;
  logic               row_ok, col_ok;

  logic               out_valid_r, out_error_r, out_last_r;
  logic [2:0]         out_row_r, out_col_r;
  logic signed [31:0] out_value_r;

  assign ri = cmd.ri[IW-1:0];
  assign rj = cmd.rj[IW-1:0];
  assign row_ok = ({1'b0, in_row} < 4'(MAX_ORDER));
  assign col_ok = ({1'b0, in_col} < 4'(MAX_ORDER));
  assign wr_addr = {in_row[IW-1:0], in_col[IW-1:0]};
  assign rd_addr = {ri, rj};

  always_ff @(posedge clk) begin
    if (cmd.load && in_target == TGT_LOWER && row_ok && col_ok) begin
      low_mem[wr_addr] <= in_value;
    end
    if (cmd.mem_rd) begin
      low_rd_r <= low_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_target == TGT_UPPER && row_ok && col_ok) begin
      up_mem[wr_addr] <= in_value;
    end
    if (cmd.mem_rd) begin
      up_rd_r <= up_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_target == TGT_RHS && row_ok) begin
      rhs_r[in_row[IW-1:0]] <= in_value;
    end
  end

  assign op_rd = cmd.back ? up_rd_r : low_rd_r;
  assign vec = cmd.back ? sol_r[rj] : fwd_r[rj];
  assign rnd = (prod_r + HALF) >>> FRAC_BITS;
  assign diff = 65'(acc_r) - 65'(rnd);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= 64'(vec) * 64'(op_rd);
      verr_r <= cmd.back ? sol_err_r[rj] : fwd_err_r[rj];
    end
    if (cmd.acc_init) begin
      if (cmd.back) begin
        acc_r <= fwd_r[ri];
        err_r <= fwd_err_r[ri];
      end else begin
        acc_r <= cmd.unit ? ((cmd.ri == cmd.oc) ? ONE : 32'sd0) : rhs_r[ri];
        err_r <= 1'b0;
      end
    end else if (cmd.acc_upd) begin
      if (diff > SMAX) begin
        acc_r <= 32'sh7fff_ffff;
        err_r <= 1'b1;
      end else if (diff < SMIN) begin
        acc_r <= 32'sh8000_0000;
        err_r <= 1'b1;
      end else begin
        acc_r <= diff[31:0];
        err_r <= err_r | verr_r;
      end
    end
  end

  luts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_r),
    .divisor  (up_rd_r),
    .done     (div_done),
    .quot     (div_q),
    .err      (div_err)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        fwd_r[k] <= '0;
        sol_r[k] <= '0;
      end
      fwd_err_r <= '0;
      sol_err_r <= '0;
    end else begin
      if (cmd.fwd_wr) begin
        fwd_r[ri]     <= acc_r;
        fwd_err_r[ri] <= err_r;
      end
      if (cmd.sol_wr) begin
        sol_r[ri]     <= div_q;
        sol_err_r[ri] <= err_r | div_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_row_r   <= cmd.ri;
      out_col_r   <= cmd.oc;
      out_value_r <= sol_r[ri];
      out_error_r <= sol_err_r[ri];
      out_last_r  <= cmd.out_last;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_row = out_row_r;
  assign out_col = out_col_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;
  assign out_last = out_last_r;

endmodule

// ===== src/luts_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences forward and back substitution and the result stream.
// Depends on luts_pkg.
module luts_ctrl import luts_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_start_req,
  output logic             in_ready,
  input  logic [SIZEW-1:0] cfg_size,
  input  logic             cfg_mode,
  output cmd_t             cmd,
  input  sts_t             sts
);

  localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   i_r, i_nxt, j_r, j_nxt, c_r, c_nxt, nm1_r, nm1_nxt;
  logic            back_r, back_nxt, mode_r, mode_nxt;
  logic [SIZEW-1:0] n_eff;

  always_comb begin
    if (cfg_size == '0) begin
      n_eff = SIZEW'(1);
    end else if (cfg_size > SIZEW'(MAX_ORDER)) begin
      n_eff = SIZEW'(MAX_ORDER);
    end else begin
      n_eff = cfg_size;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    c_nxt = c_r;
    nm1_nxt = nm1_r;
    back_nxt = back_r;
    mode_nxt = mode_r;
    cmd = '0;
    cmd.back = back_r;
    cmd.unit = mode_r;
    cmd.ri = IDXW'(i_r);
    cmd.rj = IDXW'(j_r);
    cmd.oc = (mode_r == MODE_INVERT) ? IDXW'(c_r) : '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && in_start_req) begin
          nm1_nxt = IW'(n_eff - SIZEW'(1));
          mode_nxt = cfg_mode;
          c_nxt = '0;
          i_nxt = '0;
          back_nxt = 1'b0;
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.acc_init = 1'b1;
        if (!back_r) begin
          j_nxt = '0;
          state_nxt = (i_r != '0) ? S_RD : S_FST;
        end else begin
          j_nxt = nm1_r;
          state_nxt = (i_r != nm1_r) ? S_RD : S_RDD;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_upd = 1'b1;
        if (!back_r) begin
          if (j_r + IW'(1) < i_r) begin
            j_nxt = j_r + IW'(1);
            state_nxt = S_RD;
          end else begin
            state_nxt = S_FST;
          end
        end else begin
          if (j_r - IW'(1) > i_r) begin
            j_nxt = j_r - IW'(1);
            state_nxt = S_RD;
          end else begin
            state_nxt = S_RDD;
          end
        end
      end
      S_FST: begin
        cmd.fwd_wr = 1'b1;
        if (i_r == nm1_r) begin
          back_nxt = 1'b1;
        end else begin
          i_nxt = i_r + IW'(1);
        end
        state_nxt = S_INIT;
      end
      S_RDD: begin
        cmd.mem_rd = 1'b1;
        cmd.rj = IDXW'(i_r);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.sol_wr = 1'b1;
          if (i_r == '0) begin
            state_nxt = S_EMIT;
          end else begin
            i_nxt = i_r - IW'(1);
            state_nxt = S_INIT;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.out_last = (i_r == nm1_r) && (mode_r == MODE_SOLVE || c_r == nm1_r);
          if (i_r == nm1_r) begin
            if (mode_r == MODE_INVERT && c_r != nm1_r) begin
              c_nxt = c_r + IW'(1);
              i_nxt = '0;
              back_nxt = 1'b0;
              state_nxt = S_INIT;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            i_nxt = i_r + IW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r <= '0;
      j_r <= '0;
      c_r <= '0;
      nm1_r <= '0;
      back_r <= 1'b0;
      mode_r <= MODE_SOLVE;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      c_r <= c_nxt;
      nm1_r <= nm1_nxt;
      back_r <= back_nxt;
      mode_r <= mode_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free) else $error("result loaded over a held result");
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (i_r <= nm1_r && c_r <= nm1_r))
    else $error("row or column counter beyond order");
  a_back_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && back_r) |-> (j_r > i_r))
    else $error("upper factor read outside strict upper part");
  a_fwd_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD && !back_r) |-> (j_r < i_r))
    else $error("lower factor read outside strict lower part");
`endif

endmodule

// ===== src/lu_triangular_solve_inverse.sv =====
`timescale 1ns / 1ps
// LU triangular solve and inverse: load channel, result channel, register port.
// Depends on luts_pkg, luts_if, luts_ctrl and luts_dp.
//
// Usage: the load channel carries one request per matrix element. target selects
// the lower factor, the upper factor or the right-hand side; each request is
// stored on acceptance. A request with start_req set is stored first, then the
// block solves L*U*x = b (L unit lower, its diagonal never read) with the order
// and mode in the configuration registers. In solve mode n results leave on the
// result channel, one per row; in invert mode n*n results leave column by
// column. last marks the final result of a run. error flags a zero divisor or a
// saturation that reached the element. While a run is busy the load channel is
// held off; loads resume after the last result has been handed to the result
// register.
// Sequencing: each multiply-accumulate step is a memory read, a registered
// multiply and a subtract with saturation; each diagonal division reads the
// diagonal, starts the divider and takes one quotient bit per cycle over
// 32 + FRAC_BITS bits (a zero divisor skips the bits) before it signals done.
// Results are held in an output register; when the receiver stalls, the
// controller waits with the next result and the run pauses.
// Reset (synchronous, active low) returns to idle, sets order 8 and solve mode,
// clears the working vectors and drops any pending result. The factor stores
// keep no reset value and must be written before they are used.
module lu_triangular_solve_inverse import luts_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  luts_in_if.sink              in_ch,
  luts_out_if.source           out_ch,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [CFG_ADDRW-1:0] cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  logic [SIZEW-1:0] size_r;
  logic             mode_r;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  // Configuration registers; the word index is the address divided by four.
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RST;
      mode_r <= MODE_SOLVE;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SIZE) begin
        size_r <= cfg_pwdata[SIZEW-1:0];
      end else begin
        mode_r <= cfg_pwdata[0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SIZE) ? {{(32-SIZEW){1'b0}}, size_r}
                                                 : {31'd0, mode_r};

  luts_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_start_req (in_ch.start_req),
    .in_ready     (in_ch.ready),
    .cfg_size     (size_r),
    .cfg_mode     (mode_r),
    .cmd          (cmd),
    .sts          (sts)
  );

  luts_dp #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_target (in_ch.target),
    .in_row    (in_ch.row),
    .in_col    (in_ch.col),
    .in_value  (in_ch.value),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_value (out_ch.out_value),
    .out_error (out_ch.error),
    .out_last  (out_ch.last)
  );

endmodule
